>>> hdl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg: shared types and codes for the circular list store
// Request codes, result status codes and the per-cell shift command.
// ----------------------------------------------------------------------------
package cls_pkg;

    // request codes on func
    localparam logic [1:0] FUNC_PUSH_HEAD = 2'd0;
    localparam logic [1:0] FUNC_PUSH_TAIL = 2'd1;
    localparam logic [1:0] FUNC_DELETE    = 2'd2;
    localparam logic [1:0] FUNC_READ_ALL  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [1:0] STATUS_BADPOS = 2'd3;

    // width of count and position fields carried to the cells (covers 256)
    localparam int CNT_MAX_W = 9;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_HEAD,
        CMD_PUSH_TAIL,
        CMD_DELETE,
        CMD_ROTATE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [CNT_MAX_W-1:0]  occ;   // element count before the move
        logic [CNT_MAX_W-1:0]  pos;   // 1-based delete position
    } cell_ctrl_t;

endpackage

>>> hdl/cls_cell.sv
// ----------------------------------------------------------------------------
// cls_cell: one storage cell of the list chain
// Holds one element and picks its next value from itself, its neighbors,
// the head cell or the incoming value, per the broadcast command.
// ----------------------------------------------------------------------------
module cls_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  cls_pkg::cell_ctrl_t     ctrl,
    input  logic [DATA_WIDTH-1:0]   in_value,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    input  logic [DATA_WIDTH-1:0]   head_data,
    output logic [DATA_WIDTH-1:0]   data
);

    localparam logic [cls_pkg::CNT_MAX_W-1:0] IDX      = cls_pkg::CNT_MAX_W'(INDEX);
    localparam logic [cls_pkg::CNT_MAX_W-1:0] IDX_PLUS = cls_pkg::CNT_MAX_W'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        case (ctrl.op)
            cls_pkg::CMD_PUSH_HEAD:
                data_next = left_data;
            cls_pkg::CMD_PUSH_TAIL:
                data_next = (ctrl.occ == IDX) ? in_value : data_reg;
            cls_pkg::CMD_DELETE:
                data_next = (IDX_PLUS >= ctrl.pos) ? right_data : data_reg;
            cls_pkg::CMD_ROTATE:
                // tail of the live list wraps around to the head
                data_next = (IDX_PLUS == ctrl.occ) ? head_data : right_data;
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> hdl/circular_list_store_top.sv
// ----------------------------------------------------------------------------
// circular_list_store_top: bounded ordered list held in a chain of cells
// Insert at head or tail, delete by position, read the whole list out.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer happens on a rising edge with start high and busy low;
//   func, value and position are sampled then.
//   Head insert shifts all cells, tail insert fills one, delete shifts the
//   cells past it; status (last = 1) is on the next cycle with strobe high.
//   Back-to-back inserts and deletes run at one request per cycle.
//   Read out emits one element per cycle, head first, for N elements: the
//   first result comes on the cycle after the request, the last carries
//   last = 1. The chain rotates by one cell per element, so after N
//   elements it is back in order. busy stays high until the last element
//   is out, so no new request is taken before the read is through.
//   Read out of an empty list gives a single status result (empty).
//   Each result is valid for exactly the one cycle strobe is high; the
//   receiver has no way to stall it and must take every transfer.
//   Reset (rst_n low, asynchronous) empties the list and idles the block;
//   cell contents are left as they are and never read before written.
//   length reports the element count after each operation.
// ----------------------------------------------------------------------------
module circular_list_store_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    output logic               strobe,
    output logic signed [31:0] item_value,
    output logic               last,
    output logic [1:0]         status,
    output logic [4:0]         length
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = cls_pkg::CNT_MAX_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                state_reg,  state_next;
    logic [CNT_W-1:0]      occ_reg,    occ_next;
    logic [CNT_W-1:0]      cnt_reg,    cnt_next;
    logic                  strobe_reg, strobe_next;
    logic                  last_reg,   last_next;
    logic [1:0]            status_reg, status_next;
    logic [4:0]            length_reg, length_next;
    logic signed [31:0]    item_reg,   item_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  bad_pos;
    logic [CW-1:0]         occ_ext;
    logic [CW-1:0]         pos_ext;
    logic [DATA_WIDTH-1:0] value_ext;
    cls_pkg::cell_ctrl_t   ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    assign accept    = start && (state_reg == S_IDLE);
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign occ_ext   = CW'(occ_reg);
    assign pos_ext   = CW'(position);
    assign bad_pos   = (pos_ext == '0) || (pos_ext > occ_ext);
    // sign-extend or trim the 32-bit input into the cell width
    assign value_ext = DATA_WIDTH'(value);

    // ------------------------------------------------------------------
    // Request decode and result formation
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        status_next = cls_pkg::STATUS_OK;
        item_next   = '0;
        ctrl.op     = cls_pkg::CMD_HOLD;
        ctrl.occ    = occ_ext;
        ctrl.pos    = pos_ext;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    case (func)
                        cls_pkg::FUNC_PUSH_HEAD,
                        cls_pkg::FUNC_PUSH_TAIL:
                        begin
                            if (full)
                                status_next = cls_pkg::STATUS_FULL;
                            else
                            begin
                                ctrl.op  = (func == cls_pkg::FUNC_PUSH_HEAD) ?
                                           cls_pkg::CMD_PUSH_HEAD : cls_pkg::CMD_PUSH_TAIL;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        cls_pkg::FUNC_DELETE:
                        begin
                            if (empty)
                                status_next = cls_pkg::STATUS_EMPTY;
                            else if (bad_pos)
                                status_next = cls_pkg::STATUS_BADPOS;
                            else
                            begin
                                ctrl.op  = cls_pkg::CMD_DELETE;
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            if (empty)
                                status_next = cls_pkg::STATUS_EMPTY;
                            else
                            begin
                                // first element is taken from the head, chain rotates
                                ctrl.op   = cls_pkg::CMD_ROTATE;
                                item_next = 32'(cell_data[0]);
                                cnt_next  = CNT_W'(1);
                                if (occ_reg != CNT_W'(1))
                                begin
                                    last_next  = 1'b0;
                                    state_next = S_READ;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ctrl.op     = cls_pkg::CMD_ROTATE;
                strobe_next = 1'b1;
                item_next   = 32'(cell_data[0]);
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_next == occ_reg)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        length_next = 5'(occ_next);
    end

    // ------------------------------------------------------------------
    // State and registered result ports
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            status_reg <= cls_pkg::STATUS_OK;
            length_reg <= '0;
            item_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            length_reg <= length_next;
            item_reg   <= item_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 is the head, neighbors hand data every cycle
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = value_ext;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        cls_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .in_value   (value_ext),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[g])
        );
    end

    assign busy       = (state_reg == S_READ);
    assign strobe     = strobe_reg;
    assign item_value = item_reg;
    assign last       = last_reg;
    assign status     = status_reg;
    assign length     = length_reg;

`ifndef ASSERT_OFF
    // every accepted request produces a result on the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> strobe)
        else $error("accepted request without result");

    // a non-ok status always closes the request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != cls_pkg::STATUS_OK) |-> last)
        else $error("error status without last");

    // entering read out has just sent a non-final element
    a_read_enter: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> (strobe && !last))
        else $error("read out started without element");

    // count never exceeds the store depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("element count beyond depth");
`endif

endmodule
